// ===== rtl/crp_pkg.sv =====
// ---------------------------------------------------------------------------
// crp_pkg
// Shared constants for the circle/rectangle penetration pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package crp_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int THR_BITS       = 8;
   localparam logic [THR_BITS-1:0] THR_RESET = 8'd1;

endpackage

`default_nettype wire

// ===== rtl/crp_axis.sv =====
// ---------------------------------------------------------------------------
// crp_axis
// Two register stages: X/Y interval overlap, then threshold check, minimum
// axis selection and corner axis vector.
// ---------------------------------------------------------------------------
`default_nettype none

module crp_axis #(
   parameter int COORD_BITS = crp_pkg::COORD_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic signed [COORD_BITS-1:0]   circle_x,
   input  wire logic signed [COORD_BITS-1:0]   circle_y,
   input  wire logic        [COORD_BITS-2:0]   radius,
   input  wire logic signed [COORD_BITS-1:0]   rect_x,
   input  wire logic signed [COORD_BITS-1:0]   rect_y,
   input  wire logic        [COORD_BITS-2:0]   rect_width,
   input  wire logic        [COORD_BITS-2:0]   rect_height,
   input  wire logic [crp_pkg::THR_BITS-1:0]   thr,
   output logic                                out_valid,
   output logic                                out_hit,
   output logic                                out_corner,
   output logic                                out_far,
   output logic             [COORD_BITS+1:0]   out_best,
   output logic signed      [COORD_BITS+2:0]   out_px,
   output logic signed      [COORD_BITS+2:0]   out_py,
   output logic             [COORD_BITS-2:0]   out_ax,
   output logic             [COORD_BITS-2:0]   out_ay,
   output logic             [COORD_BITS-2:0]   out_r,
   output logic                                out_nx,
   output logic                                out_ny
);

   localparam int PW = COORD_BITS + 3;
   localparam int MW = COORD_BITS + 2;
   localparam int RW = COORD_BITS - 1;

   logic signed [PW-1:0] cx, cy, re, rl, rt, rr, rb;
   logic signed [PW-1:0] cminx, cmaxx, cminy, cmaxy;
   logic signed [PW-1:0] xpen_in, ypen_in, ux_in, uy_in;
   logic                 xsep_in, ysep_in, hasx_in, hasy_in;

   logic                 v1_ff, xsep_ff, ysep_ff, hasx_ff, hasy_ff;
   logic signed [PW-1:0] xpen_ff, ypen_ff, ux_ff, uy_ff;
   logic        [RW-1:0] r1_ff;

   always_comb begin
      cx    = PW'(circle_x);
      cy    = PW'(circle_y);
      re    = $signed(PW'(radius));
      rl    = PW'(rect_x);
      rt    = PW'(rect_y);
      rr    = rl + $signed(PW'(rect_width));
      rb    = rt + $signed(PW'(rect_height));
      cminx = cx - re;
      cmaxx = cx + re;
      cminy = cy - re;
      cmaxy = cy + re;
      xsep_in = (rl > cmaxx) || (cminx > rr);
      ysep_in = (rt > cmaxy) || (cminy > rb);
      xpen_in = (rl + rr > cx + cx) ? rl - cmaxx : rr - cminx;
      ypen_in = (rt + rb > cy + cy) ? rt - cmaxy : rb - cminy;
      hasx_in = (rl > cx) || (rr < cx);
      hasy_in = (rt > cy) || (rb < cy);
      ux_in   = (rl > cx) ? cx - rl : cx - rr;
      uy_in   = (rt > cy) ? cy - rt : cy - rb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      xsep_ff <= xsep_in;
      ysep_ff <= ysep_in;
      xpen_ff <= xpen_in;
      ypen_ff <= ypen_in;
      hasx_ff <= hasx_in;
      hasy_ff <= hasy_in;
      ux_ff   <= ux_in;
      uy_ff   <= uy_in;
      r1_ff   <= radius;
   end

   logic signed [PW-1:0] xabs, yabs, axabs, ayabs;
   logic        [MW-1:0] xmag, ymag, best_in;
   logic signed [PW-1:0] px_in, py_in;
   logic                 hit_in, far_in;

   always_comb begin
      xabs  = xpen_ff[PW-1] ? -xpen_ff : xpen_ff;
      yabs  = ypen_ff[PW-1] ? -ypen_ff : ypen_ff;
      axabs = ux_ff[PW-1] ? -ux_ff : ux_ff;
      ayabs = uy_ff[PW-1] ? -uy_ff : uy_ff;
      xmag  = xabs[MW-1:0];
      ymag  = yabs[MW-1:0];
      hit_in = !xsep_ff && (xmag >= MW'(thr)) && !ysep_ff && (ymag >= MW'(thr));
      if (ymag < xmag) begin
         best_in = ymag;
         px_in   = '0;
         py_in   = ypen_ff;
      end else begin
         best_in = xmag;
         px_in   = xpen_ff;
         py_in   = '0;
      end
      far_in = (axabs > $signed(PW'(r1_ff))) || (ayabs > $signed(PW'(r1_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= v1_ff;
      end
      out_hit    <= hit_in;
      out_corner <= hasx_ff && hasy_ff;
      out_far    <= far_in;
      out_best   <= best_in;
      out_px     <= px_in;
      out_py     <= py_in;
      out_ax     <= axabs[RW-1:0];
      out_ay     <= ayabs[RW-1:0];
      out_r      <= r1_ff;
      out_nx     <= ux_ff[PW-1];
      out_ny     <= uy_ff[PW-1];
   end

endmodule

`default_nettype wire

// ===== rtl/crp_sqrt.sv =====
// ---------------------------------------------------------------------------
// crp_sqrt
// Pipelined digit-by-digit square root, one root bit per stage, then a
// round-to-nearest stage. Sideband word travels with each item.
// ---------------------------------------------------------------------------
`default_nettype none

module crp_sqrt #(
   parameter int W      = crp_pkg::COORD_BITS_DEF,
   parameter int SIDE_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [2*W-1:0]      in_s,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output logic [W-1:0]             out_root,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int RM = W + 2;

   logic              vld_ff  [0:W-1];
   logic [W-1:0]      root_ff [0:W-1];
   logic [RM-1:0]     rem_ff  [0:W-1];
   logic [2*W-1:0]    s_ff    [0:W-1];
   logic [SIDE_W-1:0] side_ff [0:W-1];

   genvar k;
   generate
      for (k = 0; k < W; k++) begin : g_stage
         logic              v_q;
         logic [W-1:0]      root_q;
         logic [RM-1:0]     rem_q;
         logic [2*W-1:0]    s_q;
         logic [SIDE_W-1:0] side_q;
         logic [RM+1:0]     rem2, trial;
         logic              ge;
         if (k == 0) begin : g_first
            assign v_q    = in_valid;
            assign root_q = '0;
            assign rem_q  = '0;
            assign s_q    = in_s;
            assign side_q = in_side;
         end else begin : g_next
            assign v_q    = vld_ff[k-1];
            assign root_q = root_ff[k-1];
            assign rem_q  = rem_ff[k-1];
            assign s_q    = s_ff[k-1];
            assign side_q = side_ff[k-1];
         end
         assign rem2  = {rem_q, s_q[2*W-1 -: 2]};
         assign trial = (RM+2)'({root_q, 2'b01});
         assign ge    = rem2 >= trial;
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= v_q;
            end
            root_ff[k] <= {root_q[W-2:0], ge};
            rem_ff[k]  <= ge ? RM'(rem2 - trial) : RM'(rem2);
            s_ff[k]    <= s_q << 2;
            side_ff[k] <= side_q;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= vld_ff[W-1];
      end
      out_root <= root_ff[W-1] + W'(rem_ff[W-1] > RM'(root_ff[W-1]));
      out_side <= side_ff[W-1];
   end

endmodule

`default_nettype wire

// ===== rtl/crp_div.sv =====
// ---------------------------------------------------------------------------
// crp_div
// Pipelined restoring divider: adds a rounding bias, then one quotient bit
// per stage. Quotient must fit W bits.
// ---------------------------------------------------------------------------
`default_nettype none

module crp_div #(
   parameter int W      = crp_pkg::COORD_BITS_DEF,
   parameter int SIDE_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [2*W-1:0]      in_num,
   input  wire logic [W-1:0]        in_bias,
   input  wire logic [W-1:0]        in_den,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output logic [W-1:0]             out_quo,
   output logic [SIDE_W-1:0]        out_side
);

   logic              vld_ff  [0:W];
   logic [W-1:0]      rem_ff  [0:W];
   logic [W-1:0]      low_ff  [0:W];
   logic [W-1:0]      den_ff  [0:W];
   logic [SIDE_W-1:0] side_ff [0:W];
   logic [2*W-1:0]    sum_in;

   assign sum_in = in_num + (2*W)'(in_bias);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0]  <= sum_in[2*W-1:W];
      low_ff[0]  <= sum_in[W-1:0];
      den_ff[0]  <= in_den;
      side_ff[0] <= in_side;
   end

   genvar k;
   generate
      for (k = 0; k < W; k++) begin : g_stage
         logic [W:0] rem2;
         logic       ge;
         assign rem2 = {rem_ff[k], low_ff[k][W-1]};
         assign ge   = rem2 >= {1'b0, den_ff[k]};
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k+1] <= 1'b0;
            end else begin
               vld_ff[k+1] <= vld_ff[k];
            end
            rem_ff[k+1]  <= ge ? W'(rem2 - {1'b0, den_ff[k]}) : W'(rem2);
            low_ff[k+1]  <= {low_ff[k][W-2:0], ge};
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   endgenerate

   assign out_valid = vld_ff[W];
   assign out_quo   = low_ff[W];
   assign out_side  = side_ff[W];

endmodule

`default_nettype wire

// ===== rtl/circle_rect_penetration_top.sv =====
// ---------------------------------------------------------------------------
// circle_rect_penetration_top
// Circle versus axis-aligned rectangle separating-axis test with minimum
// push vector, fully pipelined.
//
//   channel   ports                       handshake
//   request   req_* fields                start (taken when busy is low)
//   response  rsp_hit, rsp_push_x/y       rsp_valid strobe, one cycle
//   config    csr_wdata                   csr_we
//
// One word enters per cycle; busy stays low. The pipeline depth is set by
// the square root (one root bit per stage) and the divider (one quotient
// bit per stage). Synchronous reset clears all valid bits and loads the
// threshold with 1. The response side takes every word as shown.
// ---------------------------------------------------------------------------
`default_nettype none

module circle_rect_penetration_top #(
   parameter int COORD_BITS = crp_pkg::COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_BITS-1:0]  req_circle_x,
   input  wire logic signed [COORD_BITS-1:0]  req_circle_y,
   input  wire logic        [COORD_BITS-2:0]  req_radius,
   input  wire logic signed [COORD_BITS-1:0]  req_rect_x,
   input  wire logic signed [COORD_BITS-1:0]  req_rect_y,
   input  wire logic        [COORD_BITS-2:0]  req_rect_width,
   input  wire logic        [COORD_BITS-2:0]  req_rect_height,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic signed      [COORD_BITS+1:0]  rsp_push_x,
   output logic signed      [COORD_BITS+1:0]  rsp_push_y,
   input  wire logic                          csr_we,
   input  wire logic [crp_pkg::THR_BITS-1:0]  csr_wdata
);

   localparam int C       = COORD_BITS;
   localparam int PW      = C + 3;
   localparam int MW      = C + 2;
   localparam int RW      = C - 1;
   localparam int LATENCY = 2 * C + 9;
   // sideband through the square root
   localparam int SQ_SW   = 4 + MW + 2 * PW + 3 * RW + 2;
   // sideband through the x divider
   localparam int DV_SW   = 6 + 2 * PW + 1;

   logic [crp_pkg::THR_BITS-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= crp_pkg::THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   // axis stages
   logic                 a_valid, a_hit, a_corner, a_far, a_nx, a_ny;
   logic        [MW-1:0] a_best;
   logic signed [PW-1:0] a_px, a_py;
   logic        [RW-1:0] a_ax, a_ay, a_r;

   crp_axis #(.COORD_BITS(C)) u_axis (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start && !busy),
      .circle_x    (req_circle_x),
      .circle_y    (req_circle_y),
      .radius      (req_radius),
      .rect_x      (req_rect_x),
      .rect_y      (req_rect_y),
      .rect_width  (req_rect_width),
      .rect_height (req_rect_height),
      .thr         (thr_ff),
      .out_valid   (a_valid),
      .out_hit     (a_hit),
      .out_corner  (a_corner),
      .out_far     (a_far),
      .out_best    (a_best),
      .out_px      (a_px),
      .out_py      (a_py),
      .out_ax      (a_ax),
      .out_ay      (a_ay),
      .out_r       (a_r),
      .out_nx      (a_nx),
      .out_ny      (a_ny)
   );

   // squares
   logic                 q_valid_ff, q_hit_ff, q_corner_ff, q_far_ff, q_nx_ff, q_ny_ff;
   logic        [MW-1:0] q_best_ff;
   logic signed [PW-1:0] q_px_ff, q_py_ff;
   logic        [RW-1:0] q_ax_ff, q_ay_ff, q_r_ff;
   logic      [2*RW-1:0] sqx_ff, sqy_ff, sqr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= a_valid;
      end
      q_hit_ff    <= a_hit;
      q_corner_ff <= a_corner;
      q_far_ff    <= a_far;
      q_nx_ff     <= a_nx;
      q_ny_ff     <= a_ny;
      q_best_ff   <= a_best;
      q_px_ff     <= a_px;
      q_py_ff     <= a_py;
      q_ax_ff     <= a_ax;
      q_ay_ff     <= a_ay;
      q_r_ff      <= a_r;
      sqx_ff      <= a_ax * a_ax;
      sqy_ff      <= a_ay * a_ay;
      sqr_ff      <= a_r * a_r;
   end

   // sum of squares, compare with r squared
   logic                 s_valid_ff, s_sgt_ff;
   logic       [2*C-1:0] s_sum_ff;
   logic     [SQ_SW-1:0] s_side_ff;
   logic       [2*C-1:0] s_sum_in;

   assign s_sum_in = (2*C)'(sqx_ff) + (2*C)'(sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= q_valid_ff;
      end
      s_sum_ff  <= s_sum_in;
      s_sgt_ff  <= s_sum_in > (2*C)'(sqr_ff);
      s_side_ff <= {q_hit_ff, q_corner_ff, q_far_ff, 1'b0, q_best_ff, q_px_ff, q_py_ff,
                    q_ax_ff, q_ay_ff, q_r_ff, q_nx_ff, q_ny_ff};
   end

   logic                 r_valid;
   logic         [C-1:0] r_root;
   logic     [SQ_SW-1:0] r_side, r_side_fix;

   assign r_side_fix = {s_side_ff[SQ_SW-1 -: 3], s_sgt_ff, s_side_ff[SQ_SW-5:0]};

   crp_sqrt #(.W(C), .SIDE_W(SQ_SW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid_ff),
      .in_s      (s_sum_ff),
      .in_side   (r_side_fix),
      .out_valid (r_valid),
      .out_root  (r_root),
      .out_side  (r_side)
   );

   logic                 r_hit, r_corner, r_far, r_sgt, r_nx, r_ny;
   logic        [MW-1:0] r_best;
   logic signed [PW-1:0] r_px, r_py;
   logic        [RW-1:0] r_ax, r_ay, r_r;

   assign {r_hit, r_corner, r_far, r_sgt, r_best, r_px, r_py, r_ax, r_ay, r_r, r_nx, r_ny}
      = r_side;

   // penetration on the corner axis
   logic        [RW-1:0] m_in;
   logic                 m_valid_ff, m_low_ff, m_use_ff;
   logic        [RW-1:0] m_ff, m_ax_ff, m_ay_ff;
   logic         [C-1:0] m_d_ff;
   logic         [5:0]   m_flags_ff;
   logic signed [PW-1:0] m_px_ff, m_py_ff;

   assign m_in = r_r - r_root[RW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= r_valid;
      end
      m_ff       <= m_in;
      m_low_ff   <= MW'(m_in) < MW'(thr_ff);
      m_use_ff   <= MW'(m_in) < r_best;
      m_d_ff     <= r_root;
      m_ax_ff    <= r_ax;
      m_ay_ff    <= r_ay;
      m_flags_ff <= {r_hit, r_corner, r_far, r_sgt, r_nx, r_ny};
      m_px_ff    <= r_px;
      m_py_ff    <= r_py;
   end

   // scale products
   logic                 p_valid_ff, p_ny_ff;
   logic      [2*RW-1:0] p_x_ff, p_y_ff;
   logic         [C-1:0] p_d_ff;
   logic     [DV_SW-1:0] p_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= m_valid_ff;
      end
      p_x_ff    <= m_ax_ff * m_ff;
      p_y_ff    <= m_ay_ff * m_ff;
      p_d_ff    <= m_d_ff;
      p_side_ff <= {m_flags_ff[5:2], m_low_ff, m_use_ff, m_px_ff, m_py_ff, m_flags_ff[1]};
      p_ny_ff   <= m_flags_ff[0];
   end

   logic                 dx_valid, dy_valid, dy_ny;
   logic         [C-1:0] dx_q, dy_q;
   logic     [DV_SW-1:0] dx_side;

   crp_div #(.W(C), .SIDE_W(DV_SW)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid_ff),
      .in_num    ((2*C)'(p_x_ff)),
      .in_bias   (p_d_ff >> 1),
      .in_den    (p_d_ff),
      .in_side   (p_side_ff),
      .out_valid (dx_valid),
      .out_quo   (dx_q),
      .out_side  (dx_side)
   );

   crp_div #(.W(C), .SIDE_W(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid_ff),
      .in_num    ((2*C)'(p_y_ff)),
      .in_bias   (p_d_ff >> 1),
      .in_den    (p_d_ff),
      .in_side   (p_ny_ff),
      .out_valid (dy_valid),
      .out_quo   (dy_q),
      .out_side  (dy_ny)
   );

   // final select and saturate
   logic                 f_hit, f_corner, f_far, f_sgt, f_low, f_use, f_nx;
   logic signed [PW-1:0] f_px, f_py, cqx, cqy, px_in, py_in;
   logic                 hit_in;

   assign {f_hit, f_corner, f_far, f_sgt, f_low, f_use, f_px, f_py, f_nx} = dx_side;

   function automatic logic signed [MW-1:0] sat(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] hi, lo;
      hi = $signed({2'b00, {(C+1){1'b1}}});
      lo = $signed({2'b11, {(C+1){1'b0}}});
      if (v > hi) begin
         sat = hi[MW-1:0];
      end else if (v < lo) begin
         sat = lo[MW-1:0];
      end else begin
         sat = v[MW-1:0];
      end
   endfunction

   always_comb begin
      cqx    = $signed(PW'(dx_q));
      cqy    = $signed(PW'(dy_q));
      if (f_nx) begin
         cqx = -cqx;
      end
      if (dy_ny) begin
         cqy = -cqy;
      end
      hit_in = f_hit && (!f_corner || (!f_far && !f_sgt && !f_low));
      px_in  = f_px;
      py_in  = f_py;
      if (f_corner && f_use) begin
         px_in = cqx;
         py_in = cqy;
      end
      if (!hit_in) begin
         px_in = '0;
         py_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= dx_valid;
      end
      rsp_hit    <= hit_in;
      rsp_push_x <= sat(px_in);
      rsp_push_y <= sat(py_in);
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted word did not produce a response");

   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("response without a matching request");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_push_x == '0 && rsp_push_y == '0))
      else $error("push vector nonzero on a miss");

   a_lanes: assert property (@(posedge clock) disable iff (reset)
      dx_valid == dy_valid)
      else $error("divider lanes out of step");

endmodule

`default_nettype wire
